// File: rtl/core/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the indexed sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int IDX_W   = 7;
  localparam int CNTO_W  = 7;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_GET      = 3'd2,
    CMD_INDEX_OF = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BOUNDS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RD_CNT_M1 = 3'd0,
    RD_PTR_M1 = 3'd1,
    RD_POS_P1 = 3'd2,
    RD_PTR_P1 = 3'd3,
    RD_POS    = 3'd4,
    RD_ZERO   = 3'd5
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_VAL_POS = 2'd0,
    WR_UP      = 2'd1,
    WR_DN      = 2'd2
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    res_load;
    status_t res_status;
    logic    res_data_rd;
    logic    res_found_ptr;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic pos_eq_cnt;
    logic pos_is_last;
    logic cnt_full;
    logic cnt_zero;
    logic ptr_eq_pos;
    logic ptr_is_last;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/iss_dp.sv
// ----------------------------------------------------------------------------
// iss_dp
// Datapath: entry memory, count, walk pointer, result and output registers.
// ----------------------------------------------------------------------------
module iss_dp
  import iss_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VAL_W-1:0]   in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ST_W-1:0]    out_status,
  output logic [VAL_W-1:0]   out_read_data,
  output logic [IDX_W-1:0]   out_found_index,
  output logic [CNTO_W-1:0]  out_entry_count,
  output logic               out_is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0]  mem [CAPACITY];

  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [AW-1:0]     ptr_r;
  logic [VAL_W-1:0]  rd_data_r;

  logic [ST_W-1:0]   res_status_r;
  logic [VAL_W-1:0]  res_data_r;
  logic [IDX_W-1:0]  res_found_r;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [VAL_W-1:0]  out_data_r;
  logic [IDX_W-1:0]  out_found_r;
  logic [CNTO_W-1:0] out_count_r;
  logic              out_empty_r;

  logic [WW-1:0]     posw;
  logic [WW-1:0]     cntw;
  logic [WW-1:0]     ptrw;
  logic [AW-1:0]     pos_a;
  logic [AW-1:0]     last_a;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;

  assign posw   = WW'(pos_r);
  assign cntw   = WW'(cnt_r);
  assign ptrw   = WW'(ptr_r);
  assign pos_a  = posw[AW-1:0];
  assign last_a = AW'(cnt_r - CW'(1));

  always_comb begin
    case (cmd.rd_sel)
      RD_CNT_M1: rd_addr = last_a;
      RD_PTR_M1: rd_addr = ptr_r - AW'(1);
      RD_POS_P1: rd_addr = pos_a + AW'(1);
      RD_PTR_P1: rd_addr = ptr_r + AW'(1);
      RD_POS:    rd_addr = pos_a;
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_UP: begin
        wr_addr = ptr_r + AW'(1);
        wr_data = rd_data_r;
      end
      WR_DN: begin
        wr_addr = ptr_r - AW'(1);
        wr_data = rd_data_r;
      end
      default: begin
        wr_addr = pos_a;
        wr_data = val_r;
      end
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CW'(1);
      CNT_DEC: cnt_nxt = cnt_r - CW'(1);
      CNT_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      ptr_r     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      if (cmd.res_status != ST_OK) begin
        res_data_r <= '1;
      end else if (cmd.res_data_rd) begin
        res_data_r <= rd_data_r;
      end else begin
        res_data_r <= '0;
      end
      res_found_r <= cmd.res_found_ptr ? ptrw[IDX_W-1:0] : '1;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
      out_found_r  <= res_found_r;
      out_count_r  <= cntw[CNTO_W-1:0];
      out_empty_r  <= (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd         = cmd_t'(cmd_r);
    stat.pos_gt_cnt  = (posw > cntw);
    stat.pos_ge_cnt  = (posw >= cntw);
    stat.pos_eq_cnt  = (posw == cntw);
    stat.pos_is_last = (cnt_r != '0) && (posw == cntw - WW'(1));
    stat.cnt_full    = (cnt_r == CW'(CAPACITY));
    stat.cnt_zero    = (cnt_r == '0);
    stat.ptr_eq_pos  = (ptrw == posw);
    stat.ptr_is_last = (ptr_r == last_a);
    stat.match       = (rd_data_r == val_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_data_r;
  assign out_found_index = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;

endmodule

// File: rtl/core/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// Controller: sequences check, shift, search and response steps per word.
// ----------------------------------------------------------------------------
module iss_ctrl
  import iss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHUP,
    S_PLACE,
    S_SHDN,
    S_GETW,
    S_SRCH,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_ZERO;
    cmd.wr_sel     = WR_VAL_POS;
    cmd.cnt_op     = CNT_HOLD;
    cmd.res_status = ST_OK;
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_RESP;
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.pos_gt_cnt) begin
              cmd.res_status = ST_BOUNDS;
            end else if (stat.cnt_full) begin
              cmd.res_status = ST_FULL;
            end else if (stat.pos_eq_cnt) begin
              cmd.wr_en  = 1'b1;
              cmd.cnt_op = CNT_INC;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_CNT_M1;
              state_nxt    = S_SHUP;
            end
          end
          CMD_REMOVE: begin
            if (stat.pos_ge_cnt) begin
              cmd.res_status = ST_BOUNDS;
            end else if (stat.pos_is_last) begin
              cmd.cnt_op = CNT_DEC;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_POS_P1;
              state_nxt    = S_SHDN;
            end
          end
          CMD_GET: begin
            if (stat.pos_ge_cnt) begin
              cmd.res_status = ST_BOUNDS;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_POS;
              state_nxt    = S_GETW;
            end
          end
          CMD_INDEX_OF: begin
            if (stat.cnt_zero) begin
              cmd.res_status = ST_NOT_FOUND;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_ZERO;
              state_nxt    = S_SRCH;
            end
          end
          CMD_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end
      S_SHUP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_UP;
        if (stat.ptr_eq_pos) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
        end
      end
      S_PLACE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = WR_VAL_POS;
        cmd.cnt_op   = CNT_INC;
        cmd.res_load = 1'b1;
        state_nxt    = S_RESP;
      end
      S_SHDN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_DN;
        if (stat.ptr_is_last) begin
          cmd.cnt_op   = CNT_DEC;
          cmd.res_load = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P1;
        end
      end
      S_GETW: begin
        cmd.res_load    = 1'b1;
        cmd.res_data_rd = 1'b1;
        state_nxt       = S_RESP;
      end
      S_SRCH: begin
        if (stat.match) begin
          cmd.res_load      = 1'b1;
          cmd.res_found_ptr = 1'b1;
          state_nxt         = S_RESP;
        end else if (stat.ptr_is_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_P1;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: rtl/core/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered store of signed 32-bit values with insert, remove, get, search
// and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one command word: in_tuser carries the command,
//   in_tdata the position and value. Each word returns exactly one out_
//   word with status, read data, found index, count and empty flag.
//   One word is worked at a time through an entry memory with one read and
//   one write port that walks one entry a cycle. Clear, bad-index and
//   append-at-end words need no memory walk; get reads one entry; insert
//   shifts the entries from the last down to the position up by one;
//   remove shifts the entries above the position down by one; index-of
//   reads from entry 0 until a match or the last entry. The next word is
//   accepted only after the result has been loaded into the output register.
//   The result sits in an output register, so the next word is accepted
//   while it waits; a stalled out_tready holds the block in its response
//   step once the next result is ready.
//   Reset empties the store at once (count to zero, no clearing pass);
//   memory contents are undefined until written and are never read before.
// ----------------------------------------------------------------------------
module indexed_sequence_store
  import iss_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // position [6:0], value [38:7], zero [39]
  input  logic [IN_DW-1:0]  in_tdata,
  // command [2:0]
  input  logic [CMD_W-1:0]  in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status [1:0], read_data [33:2], found_index [40:34],
  // entry_count [47:41], is_empty [48], zero [55:49]
  output logic [OUT_DW-1:0] out_tdata
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic              ctrl_ready;
  logic [ST_W-1:0]   status;
  logic [VAL_W-1:0]  read_data;
  logic [IDX_W-1:0]  found_index;
  logic [CNTO_W-1:0] entry_count;
  logic              is_empty;

  iss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_tuser),
    .in_position     (in_tdata[POS_W-1:0]),
    .in_value        (in_tdata[POS_W+VAL_W-1:POS_W]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (status),
    .out_read_data   (read_data),
    .out_found_index (found_index),
    .out_entry_count (entry_count),
    .out_is_empty    (is_empty)
  );

  assign in_tready = ctrl_ready;
  assign out_tdata = {7'd0, is_empty, entry_count, found_index, read_data, status};

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed sequence store. A tracker class keeps
// its own copy of the stored entries and fill count, predicts one result word
// per accepted command word and checks results in order. The stimulus is a
// short directed run over the special cases, then random fill, drain and
// mixed segments with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;
  import iss_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 80;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_ONES = 32'hffff_ffff;
  localparam logic [IDX_W-1:0] IDX_NONE = 7'h7f;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  read_data;
    logic [IDX_W-1:0]  found_index;
    logic [CNTO_W-1:0] entry_count;
    logic              is_empty;
  } store_result_t;

  class store_tracker;
    logic [VAL_W-1:0] entries [CAPACITY];
    int unsigned      fill;
    store_result_t    expected_results [$];
    int               mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [VAL_W-1:0] pick_stored();
      if (fill == 0) return $urandom;
      return entries[$urandom_range(0, fill - 1)];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      store_result_t r;
      int unsigned   p;
      p = pos;
      r.status = ST_OK;
      r.read_data = '0;
      r.found_index = IDX_NONE;
      if (cmd == CMD_INSERT) begin
        if (p > fill) begin
          r.status = ST_BOUNDS;
        end else if (fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = fill; i > p; i--) entries[i] = entries[i-1];
          entries[p] = val;
          fill++;
        end
      end else if (cmd == CMD_REMOVE) begin
        if (p >= fill) begin
          r.status = ST_BOUNDS;
        end else begin
          for (int i = p; i + 1 < fill; i++) entries[i] = entries[i+1];
          fill--;
        end
      end else if (cmd == CMD_GET) begin
        if (p >= fill) r.status = ST_BOUNDS;
        else r.read_data = entries[p];
      end else if (cmd == CMD_INDEX_OF) begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < fill; i++) begin
          if (entries[i] == val) begin
            r.status = ST_OK;
            r.found_index = i[IDX_W-1:0];
            break;
          end
        end
      end else if (cmd == CMD_CLEAR) begin
        fill = 0;
      end
      if (r.status != ST_OK) r.read_data = VAL_ONES;
      r.entry_count = fill[CNTO_W-1:0];
      r.is_empty = (fill == 0);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DW-1:0] word);
      store_result_t got, want;
      got.status      = status_t'(word[1:0]);
      got.read_data   = word[33:2];
      got.found_index = word[40:34];
      got.entry_count = word[47:41];
      got.is_empty    = word[48];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word with nothing expected: %h", word);
        return;
      end
      want = expected_results.pop_front();
      if (got.status != want.status || got.read_data != want.read_data ||
          got.found_index != want.found_index ||
          got.entry_count != want.entry_count || got.is_empty != want.is_empty) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"exp st=%0d data=%h idx=%h cnt=%0d empty=%b | ",
                    "got st=%0d data=%h idx=%h cnt=%0d empty=%b"},
                   want.status, want.read_data, want.found_index, want.entry_count,
                   want.is_empty, got.status, got.read_data, got.found_index,
                   got.entry_count, got.is_empty);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]  in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  store_tracker sb = new();
  bit           send_burst;
  bit           recv_burst;
  int           idle_cycles = 0;

  indexed_sequence_store #(.CAPACITY(CAPACITY)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, val, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, pos, val);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_ONES;
          default: return '0;
        endcase
      end
      1, 2: return $urandom_range(0, 15);
      3: return -$urandom_range(1, 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int kind);
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    r = $urandom_range(0, 99);
    case (kind)
      0: cmd = (r < 80) ? CMD_INSERT : (r < 88) ? CMD_GET :
               (r < 95) ? CMD_INDEX_OF : CMD_REMOVE;
      1: cmd = (r < 60) ? CMD_REMOVE : (r < 75) ? CMD_GET :
               (r < 90) ? CMD_INDEX_OF : (r < 97) ? CMD_INSERT : CMD_CLEAR;
      default: begin
        if (r < 97) begin
          cmd = (r < 30) ? CMD_INSERT : (r < 55) ? CMD_REMOVE :
                (r < 75) ? CMD_GET : (r < 93) ? CMD_INDEX_OF : CMD_CLEAR;
        end else begin
          cmd = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        end
      end
    endcase
    pos = POS_W'($urandom_range(0, CAPACITY));
    if ($urandom_range(0, 9) != 0) begin
      if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(0, sb.fill));
      else if (sb.fill > 0) pos = POS_W'($urandom_range(0, sb.fill - 1));
    end
    if (cmd == CMD_INDEX_OF && $urandom_range(0, 9) < 6) val = sb.pick_stored();
    else val = rand_value();
    send_command(cmd, pos, val);
  endtask

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("indexed_sequence_store: mismatch");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
    end
  end

  initial begin
    int sent;
    int kind;
    int len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(CMD_GET,      7'd0,  '0);
    send_command(CMD_REMOVE,   7'd0,  '0);
    send_command(CMD_INDEX_OF, 7'd0,  32'd5);
    send_command(CMD_INSERT,   7'd1,  32'd9);
    send_command(CMD_INSERT,   7'd0,  VAL_MAX);
    send_command(CMD_INSERT,   7'd0,  VAL_MIN);
    send_command(CMD_INSERT,   7'd2,  VAL_ONES);
    send_command(CMD_INSERT,   7'd1,  '0);
    send_command(CMD_INSERT,   7'd64, 32'd1);
    send_command(CMD_INSERT,   7'd1,  '0);
    send_command(CMD_INDEX_OF, 7'd0,  '0);
    send_command(CMD_INDEX_OF, 7'd0,  32'h1234_5678);
    send_command(CMD_GET,      7'd0,  '0);
    send_command(CMD_GET,      7'd4,  '0);
    send_command(CMD_GET,      7'd64, '0);
    send_command(CMD_GET,      7'd5,  '0);
    send_command(CMD_SPARE_A,  7'd64, VAL_ONES);
    send_command(CMD_SPARE_B,  7'd3,  VAL_MIN);
    send_command(CMD_SPARE_C,  7'd0,  '0);
    send_command(CMD_REMOVE,   7'd0,  '0);
    send_command(CMD_REMOVE,   7'd3,  '0);
    send_command(CMD_REMOVE,   7'd1,  '0);
    send_command(CMD_CLEAR,    7'd0,  '0);
    send_command(CMD_CLEAR,    7'd0,  '0);
    send_command(CMD_INSERT,   7'd0,  32'ha5a5_a5a5);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      len = $urandom_range(40, 120);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      send_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_random(kind);
      sent += len;
      // hold until the block has drained
      in_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("indexed_sequence_store: match");
    end else begin
      $display("indexed_sequence_store: mismatch");
    end
    $finish;
  end

endmodule
